FILE: src/periodic_stream_scheduler_macros.svh
// assertion macros for the stream scheduler
`ifndef PERIODIC_STREAM_SCHEDULER_MACROS_SVH
`define PERIODIC_STREAM_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define PSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/pss_pkg.sv
// shared types and constants of the stream scheduler
package pss_pkg;
	localparam int STREAM_COUNT = 12;
	localparam int PORT_COUNT = 2;
	localparam int SLOTS = PORT_COUNT * STREAM_COUNT;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int SW = $clog2(STREAM_COUNT);
	localparam logic [31:0] MINUS_ONE_Q16 = 32'hFFFF0000;
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_RATE = 1'b1;
	localparam logic CFG_BAUD_A = 1'b0;
	localparam logic CFG_BAUD_B = 1'b1;

	typedef struct packed {
		logic load;       // latch item
		logic scan_step;  // test one stream
		logic write_per;  // store period
	} pss_cmd_t;

	typedef struct packed {
		logic div_done;
		logic scan_last;
		logic is_rate;
	} pss_sts_t;

	function automatic logic [31:0] default_rate(input logic [1:0] tier, input logic [3:0] s);
		logic [31:0] r;
		r = 32'd0;
		case (s)
			4'd0: r = 32'd65536;
			4'd2: r = 32'd13107;
			4'd3, 4'd5: r = (tier == 2'd0) ? 32'd3276800 : (tier == 2'd1) ? 32'd655360 :
				(tier == 2'd2) ? 32'd327680 : 32'd0;
			4'd6, 4'd8: r = (tier == 2'd0) ? 32'd655360 : (tier == 2'd3) ? 32'd0 : 32'd327680;
			4'd7: r = (tier == 2'd0) ? 32'd1310720 : (tier == 2'd3) ? 32'd0 : 32'd327680;
			4'd10: r = (tier == 2'd3) ? 32'd0 : 32'd131072;
			4'd11: r = (tier == 2'd0) ? 32'd6553600 : (tier == 2'd1) ? 32'd2621440 :
				(tier == 2'd2) ? 32'd1310720 : 32'd655360;
			default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage

FILE: src/pss_ctrl.sv
// controller sequencing rate updates and tick scans
module pss_ctrl import pss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done_q,
	output pss_cmd_t cmd,
	input  pss_sts_t sts
);
	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SCAN, ST_WR} state_t;
	state_t state_q;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.write_per = (state_q == ST_WR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_DIV;
				ST_DIV: begin
					if (!sts.is_rate) state_q <= ST_SCAN;
					else if (sts.div_done) state_q <= ST_WR;
				end
				ST_SCAN: if (sts.scan_last) begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
				end
				ST_WR: begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: src/pss_dp.sv
// datapath: tables, restoring divider and stream scan
module pss_dp import pss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pss_cmd_t    cmd,
	output pss_sts_t    sts,
	input  logic [21:0] baud_a,
	input  logic [21:0] baud_b,
	input  logic        operation,
	input  logic [31:0] time_now,
	input  logic        open_a,
	input  logic        open_b,
	input  logic        port_sel,
	input  logic [3:0]  stream_sel,
	input  logic [31:0] rate_value,
	output logic        sent_a,
	output logic [3:0]  stream_a,
	output logic        sent_b,
	output logic [3:0]  stream_b
);
	logic [31:0] period_q [SLOTS];
	logic [31:0] last_q [SLOTS];
	logic        op_q, open_a_q, open_b_q, port_q, valid_q;
	logic [31:0] now_q;
	logic [SW-1:0] stream_q;
	logic [SW-1:0] idx_q;
	// restoring divider: 44-bit dividend / 33-bit divisor
	logic [43:0] quo_q;
	logic [33:0] rem_q;
	logic [32:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [33:0] trial;
	logic [31:0] eff_rate;
	logic [1:0]  tier;
	logic [21:0] baud_sel;
	logic [43:0] qsat;
	logic [31:0] per_new;
	logic [16:0] nq;
	logic [SLOT_W-1:0] slot_a;
	logic [SLOT_W-1:0] slot_b;

	assign baud_sel = port_sel ? baud_b : baud_a;
	always_comb begin
		if (baud_sel >= 22'd921600) tier = 2'd0;
		else if (baud_sel >= 22'd115200) tier = 2'd1;
		else if (baud_sel >= 22'd57600) tier = 2'd2;
		else tier = 2'd3;
		eff_rate = (rate_value == MINUS_ONE_Q16) ? default_rate(tier, stream_sel) : rate_value;
	end

	assign trial = {rem_q[32:0], quo_q[43]} - {1'b0, dvs_q};
	assign qsat = (quo_q > 44'h7FFFFFFF) ? 44'h7FFFFFFF : quo_q;
	assign nq = 17'((qsat[31:0] + 32'h8000) >> 16);
	assign per_new = (valid_q && dvs_q != '0) ? (32'(nq) * 32'd1000) : 32'd0;

	// table slots of the stream under test on each port
	assign slot_a = SLOT_W'(idx_q);
	assign slot_b = SLOT_W'(STREAM_COUNT + int'(idx_q));

	assign sts.is_rate = op_q;
	assign sts.div_done = !run_q;
	assign sts.scan_last = (idx_q == SW'(STREAM_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				period_q[i] <= '0;
				last_q[i] <= '0;
			end
			run_q <= 1'b0;
			{sent_a, sent_b, stream_a, stream_b} <= '0;
		end else begin
			if (cmd.load) begin
				op_q <= operation;
				now_q <= time_now;
				open_a_q <= open_a;
				open_b_q <= open_b;
				port_q <= port_sel;
				stream_q <= stream_sel[SW-1:0];
				valid_q <= (int'(stream_sel) < STREAM_COUNT) && (int'(port_sel) < PORT_COUNT);
				idx_q <= '0;
				{sent_a, sent_b, stream_a, stream_b} <= '0;
				// dividend 1000*2^33 + r, divisor 2r
				quo_q <= (44'd1000 << 33) + {12'd0, eff_rate};
				// zero divisor marks a disabled stream
				dvs_q <= (operation == OP_RATE && (eff_rate[31] || eff_rate == '0)) ? '0
					: {eff_rate, 1'b0};
				rem_q <= '0;
				cnt_q <= 6'd44;
				run_q <= (operation == OP_RATE) && !eff_rate[31] && eff_rate != '0;
			end
			if (run_q) begin
				if (!trial[33]) begin
					rem_q <= trial;
					quo_q <= {quo_q[42:0], 1'b1};
				end else begin
					rem_q <= {rem_q[32:0], quo_q[43]};
					quo_q <= {quo_q[42:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) run_q <= 1'b0;
			end
			if (cmd.write_per && valid_q)
				period_q[SLOT_W'(int'(port_q) * STREAM_COUNT + int'(stream_q))] <= per_new;
			if (cmd.scan_step) begin
				idx_q <= idx_q + SW'(1);
				if (open_a_q && !sent_a && period_q[slot_a] != '0
						&& (now_q - last_q[slot_a]) > period_q[slot_a]) begin
					sent_a <= 1'b1;
					stream_a <= 4'(idx_q);
					last_q[slot_a] <= now_q;
				end
				if (PORT_COUNT > 1 && open_b_q && !sent_b
						&& period_q[slot_b] != '0
						&& (now_q - last_q[slot_b]) > period_q[slot_b]) begin
					sent_b <= 1'b1;
					stream_b <= 4'(idx_q);
					last_q[slot_b] <= now_q;
				end
			end
		end
	end
endmodule

FILE: src/periodic_stream_scheduler.sv
// top level of the periodic stream scheduler
// rate update: strobe once the division is done (44-step restoring divider, one bit a cycle)
// zero or negative rate: strobe after the period write, no division
// tick: strobe after all streams are scanned, one stream of each port tested per cycle
// one item at a time; next item taken at the edge that ends the strobe cycle
// arst_n clears all periods and last send times at once, bauds reset to 921600
`include "periodic_stream_scheduler_macros.svh"
module periodic_stream_scheduler import pss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [21:0] cfg_data,
	input  logic        operation,
	input  logic [31:0] time_now,
	input  logic        open_a,
	input  logic        open_b,
	input  logic        port_sel,
	input  logic [3:0]  stream_sel,
	input  logic [31:0] rate_value,
	output logic        sent_a,
	output logic [3:0]  stream_a,
	output logic        sent_b,
	output logic [3:0]  stream_b
);
	pss_cmd_t cmd;
	pss_sts_t sts;
	logic [21:0] baud_a_q, baud_b_q;

	// config transfer accepted every cycle
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_a_q <= 22'd921600;
			baud_b_q <= 22'd921600;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_BAUD_A) baud_a_q <= cfg_data;
			else baud_b_q <= cfg_data;
		end
	end

	pss_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .done_q(done), .cmd, .sts);

	pss_dp u_dp (.clk, .arst_n, .cmd, .sts, .baud_a(baud_a_q), .baud_b(baud_b_q),
		.operation, .time_now, .open_a, .open_b, .port_sel, .stream_sel, .rate_value,
		.sent_a, .stream_a, .sent_b, .stream_b);

	// accepted item makes the block busy next cycle
	`PSS_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	// the strobe cycle is an idle cycle
	`PSS_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	// no port A send flagged on a strobe with the stream beyond range
	`PSS_ASSERT_IMPL(a_stream_rng, clk, arst_n, done && sent_a, stream_a < 4'(STREAM_COUNT))
endmodule

FILE: tb/pss_checker.sv
// checker for the stream scheduler: predicts each result and compares it with the block
module pss_checker import pss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        done,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [21:0] cfg_data,
	input  logic        operation,
	input  logic [31:0] time_now,
	input  logic        open_a,
	input  logic        open_b,
	input  logic        port_sel,
	input  logic [3:0]  stream_sel,
	input  logic [31:0] rate_value,
	input  logic        sent_a,
	input  logic [3:0]  stream_a,
	input  logic        sent_b,
	input  logic [3:0]  stream_b,
	output int          mismatches,
	output int          waiting,
	output int          sends_seen
);
	typedef struct packed {
		logic       sa;
		logic [3:0] wa;
		logic       sb;
		logic [3:0] wb;
	} sched_out_t;

	logic [31:0] period_us [SLOTS];
	logic [31:0] last_sent [SLOTS];
	logic [21:0] baud [PORT_COUNT];
	sched_out_t  outcome_q [$];

	// default rates, raw Q16.16, indexed [tier][stream]
	localparam logic [31:0] DFLT_RATES [4][12] = '{
		'{65536, 0, 13107, 3276800, 0, 3276800, 655360, 1310720, 655360, 0, 131072, 6553600},
		'{65536, 0, 13107, 655360, 0, 655360, 327680, 327680, 327680, 0, 131072, 2621440},
		'{65536, 0, 13107, 327680, 0, 327680, 327680, 327680, 327680, 0, 131072, 1310720},
		'{65536, 0, 13107, 0, 0, 0, 0, 0, 0, 0, 0, 655360}
	};

	function automatic logic [31:0] period_from_rate(input logic [31:0] r);
		logic [63:0] q;
		logic [63:0] n;
		if (r == 32'd0 || r[31])
			return 32'd0;
		q = ((64'd1000 << 33) + {32'd0, r}) / ({32'd0, r} * 64'd2);
		if (q > 64'h7FFFFFFF)
			q = 64'h7FFFFFFF;
		n = (q + 64'h8000) >> 16;
		return 32'd1000 * n[31:0];
	endfunction

	function automatic int baud_tier(input logic [21:0] b);
		if (b >= 22'd921600) return 0;
		if (b >= 22'd115200) return 1;
		if (b >= 22'd57600) return 2;
		return 3;
	endfunction

	// one port of a tick: lowest due stream wins, its send time is refreshed
	task automatic scan_port(input int p, input logic [31:0] now, output logic hit,
			output logic [3:0] idx);
		logic [31:0] elapsed;
		hit = 1'b0;
		idx = 4'd0;
		for (int s = 0; s < STREAM_COUNT; s++) begin
			elapsed = now - last_sent[p * STREAM_COUNT + s];
			if (!hit && period_us[p * STREAM_COUNT + s] != 0 &&
					elapsed > period_us[p * STREAM_COUNT + s]) begin
				hit = 1'b1;
				idx = 4'(s);
				last_sent[p * STREAM_COUNT + s] = now;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sched_out_t exp_o;
		sched_out_t got;
		logic [31:0] r;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				period_us[i] = '0;
				last_sent[i] = '0;
			end
			baud[0] = 22'd921600;
			baud[1] = 22'd921600;
			outcome_q.delete();
			mismatches = 0;
			waiting = 0;
			sends_seen = 0;
		end else begin
			// result strobe belongs to an item accepted at an earlier edge
			if (done) begin
				got = '{sent_a, stream_a, sent_b, stream_b};
				if (outcome_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", got);
				end else begin
					exp_o = outcome_q.pop_front();
					if (got !== exp_o) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %p, got %p", exp_o, got);
					end
					sends_seen += got.sa + got.sb;
				end
			end
			if (cfg_valid && cfg_ready)
				baud[cfg_index == CFG_BAUD_A ? 0 : 1] = cfg_data;
			if (start && !busy) begin
				exp_o = '0;
				if (operation == OP_RATE) begin
					if (stream_sel < STREAM_COUNT) begin
						r = rate_value;
						if (r == MINUS_ONE_Q16)
							r = DFLT_RATES[baud_tier(baud[port_sel])][stream_sel];
						period_us[port_sel * STREAM_COUNT + stream_sel] = period_from_rate(r);
					end
				end else begin
					if (open_a) scan_port(0, time_now, exp_o.sa, exp_o.wa);
					if (open_b) scan_port(1, time_now, exp_o.sb, exp_o.wb);
				end
				outcome_q.push_back(exp_o);
			end
			waiting = outcome_q.size();
		end
	end
endmodule

FILE: tb/tb_periodic_stream_scheduler.sv
// testbench top of the stream scheduler: stimulus, clock, reset and verdict
module tb_periodic_stream_scheduler;
	import pss_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [21:0] cfg_data;
	logic        operation;
	logic [31:0] time_now;
	logic        open_a;
	logic        open_b;
	logic        port_sel;
	logic [3:0]  stream_sel;
	logic [31:0] rate_value;
	logic        sent_a;
	logic [3:0]  stream_a;
	logic        sent_b;
	logic [3:0]  stream_b;
	int          mismatches;
	int          waiting;
	int          sends_seen;

	// running time of the ticks, wraps like the block's
	logic [31:0] clock_us;
	int          items_done;
	int          rate_items;
	bit          no_gaps;

	periodic_stream_scheduler DUT (.*);

	pss_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// generous fixed limit, far beyond the slowest correct run
	initial begin
		#4000000;
		$display("tb_periodic_stream_scheduler NOT OK");
		$finish;
	end

	// idle gap: mostly none or short, now and then long
	task automatic idle_gap();
		int n;
		int pick;
		pick = $urandom_range(0, 99);
		if (no_gaps || pick < 50)
			n = 0;
		else if (pick < 90)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 80);
		repeat (n) @(negedge clk);
	endtask

	// one transfer on the command channel; busy is registered, so it is stable here
	task automatic issue(input logic op, input logic [31:0] t, input logic oa, input logic ob,
			input logic p, input logic [3:0] s, input logic [31:0] r);
		idle_gap();
		while (busy) @(negedge clk);
		start = 1'b1;
		operation = op;
		time_now = t;
		open_a = oa;
		open_b = ob;
		port_sel = p;
		stream_sel = s;
		rate_value = r;
		@(negedge clk);
		start = 1'b0;
		items_done++;
		if (op == OP_RATE) rate_items++;
	endtask

	task automatic set_rate(input logic p, input logic [3:0] s, input logic [31:0] r);
		issue(OP_RATE, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), p, s, r);
	endtask

	task automatic tick_at(input logic [31:0] t, input logic oa, input logic ob);
		issue(OP_TICK, t, oa, ob, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
			$urandom);
	endtask

	// register write, only with no result outstanding
	task automatic write_baud(input logic idx, input logic [21:0] val);
		while (waiting != 0 || busy) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		while (!cfg_ready) @(negedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [21:0] pick_baud();
		case ($urandom_range(0, 9))
			0: return 22'd0;
			1: return 22'd57599;
			2: return 22'd57600;
			3: return 22'd115199;
			4: return 22'd115200;
			5: return 22'd921599;
			6: return 22'd921600;
			7: return 22'h3FFFFF;
			8: return 22'd4000000;
			default: return 22'($urandom);
		endcase
	endfunction

	// rates: mostly in the useful band, plus automatic, off, negative and raw noise
	function automatic logic [31:0] pick_rate();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) return $urandom_range(13107, 32'd200 << 16);
		if (pick < 65) return MINUS_ONE_Q16;
		if (pick < 72) return 32'd0;
		if (pick < 78) return $urandom_range(1, 13107);
		if (pick < 84) return 32'h80000000 | $urandom;
		return $urandom;
	endfunction

	function automatic logic [31:0] next_time(input logic [31:0] t);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65) return t + $urandom_range(0, 4000);
		if (pick < 85) return t + $urandom_range(4000, 300000);
		if (pick < 92) return t;
		return $urandom;
	endfunction

	initial begin
		logic [31:0] t;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BAUD_A;
		cfg_data = '0;
		operation = OP_TICK;
		time_now = '0;
		open_a = 1'b0;
		open_b = 1'b0;
		port_sel = 1'b0;
		stream_sel = '0;
		rate_value = '0;
		items_done = 0;
		rate_items = 0;
		no_gaps = 1'b0;
		clock_us = 32'd0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: tier extremes, automatic rates, edge rates, ignored streams
		write_baud(CFG_BAUD_A, 22'd0);
		write_baud(CFG_BAUD_B, 22'h3FFFFF);
		set_rate(1'b0, 4'd11, MINUS_ONE_Q16);
		set_rate(1'b1, 4'd11, MINUS_ONE_Q16);
		set_rate(1'b0, 4'd0, 32'd1);              // tiniest rate, period saturates
		set_rate(1'b1, 4'd3, 32'h7FFFFFFF);       // huge rate rounds to a zero period
		set_rate(1'b1, 4'd5, 32'd50 << 16);
		set_rate(1'b0, 4'd2, 32'h80000000);       // most negative, disables
		set_rate(1'b0, 4'd13, 32'd10 << 16);      // stream out of range, ignored
		set_rate(1'b1, 4'd15, MINUS_ONE_Q16);
		set_rate(1'b1, 4'd0, 32'd0);
		tick_at(32'd0, 1'b1, 1'b1);               // nothing elapsed yet
		tick_at(32'd150000, 1'b0, 1'b0);          // both ports closed
		tick_at(32'd150000, 1'b1, 1'b1);
		tick_at(32'd150000, 1'b1, 1'b1);          // same time, the streams just sent no longer due
		tick_at(32'hFFFFFFFF, 1'b1, 1'b1);
		tick_at(32'd40000, 1'b1, 1'b1);           // time wrapped round
		set_rate(1'b1, 4'd5, 32'hFFFFFFFF);       // just below zero
		tick_at(32'd9000000, 1'b1, 1'b0);
		tick_at(32'd9000000, 1'b0, 1'b1);
		clock_us = 32'd9000000;

		// random phases, a baud change before each
		for (int ph = 0; ph < 8; ph++) begin
			write_baud(CFG_BAUD_A, pick_baud());
			write_baud(CFG_BAUD_B, pick_baud());
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 125; i++) begin
				if ($urandom_range(0, 99) < 25) begin
					set_rate(1'($urandom_range(0, 1)),
						($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
							: 4'($urandom_range(0, 11)), pick_rate());
				end else begin
					t = next_time(clock_us);
					clock_us = t;
					tick_at(t, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
				end
			end
		end

		// let the last results drain
		while (waiting != 0 || busy) @(negedge clk);
		repeat (60) @(negedge clk);
		$display("%0d items sent, %0d of them rate updates, %0d stream sends checked",
			items_done, rate_items, sends_seen);
		if (mismatches == 0 && waiting == 0)
			$display("tb_periodic_stream_scheduler OK");
		else
			$display("tb_periodic_stream_scheduler NOT OK");
		$finish;
	end
endmodule
